[hw/rtl/lcdws_pkg.sv]
// Shared types and constants for the character LCD write sequencer.
package lcdws_pkg;

    // Request codes on the input cmd field
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_RAW    = 3'd1;
    localparam logic [2:0] CMD_DATA   = 3'd2;
    localparam logic [2:0] CMD_CURSOR = 3'd3;
    localparam logic [2:0] CMD_NUMBER = 3'd4;
    localparam logic [2:0] CMD_GLYPH  = 3'd5;

    // LCD bus opcodes
    localparam logic [7:0] OP_FUNCTION_SET = 8'h38;
    localparam logic [7:0] OP_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] OP_CLEAR        = 8'h01;
    localparam logic [3:0] ASCII_DIGIT_HI  = 4'h3;

    localparam int GLYPH_HEIGHT = 8;
    localparam int GLYPH_ROWS_W = 8 * GLYPH_HEIGHT;

    // Steps of the custom glyph sequence
    localparam logic [3:0] GSTEP_CGRAM    = 4'd0;
    localparam logic [3:0] GSTEP_LAST_ROW = 4'd8;
    localparam logic [3:0] GSTEP_CURSOR   = 4'd9;

    // Steps of the init sequence
    localparam logic [3:0] ISTEP_FUNCTION = 4'd0;
    localparam logic [3:0] ISTEP_DISPLAY  = 4'd1;

    typedef enum logic [2:0] {
        K_INIT,
        K_RAW,
        K_DATA,
        K_CURSOR,
        K_NUMBER,
        K_GLYPH
    } t_kind;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } t_back_state;

    typedef struct packed {
        t_kind                   kind;
        logic [7:0]              byte_value;
        logic [7:0]              cursor;
        logic [2:0]              slot;
        logic [GLYPH_ROWS_W-1:0] rows;
    } t_job;

endpackage

[hw/rtl/lcdws_front.sv]
// Request intake: classify each request and convert numbers to BCD.
module lcdws_front
    import lcdws_pkg::*;
#(
    parameter int NUMBER_BITS = 32,
    parameter int DIGITS      = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [2:0]              i_cmd,
    input  logic [7:0]              i_byte_value,
    input  logic                    i_row,
    input  logic [5:0]              i_column,
    input  logic [NUMBER_BITS-1:0]  i_number,
    input  logic [2:0]              i_glyph_slot,
    input  logic [GLYPH_ROWS_W-1:0] i_glyph_rows,
    output logic                    o_q_push,
    input  logic                    i_q_full,
    output t_job                    o_job,
    output logic [4*DIGITS-1:0]     o_bcd
);

    localparam int CNT_W = $clog2(NUMBER_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUMBER_BITS - 1);

    t_front_state            r_state, n_state;
    t_job                    r_job;
    logic [NUMBER_BITS-1:0]  r_bin;
    logic [4*DIGITS-1:0]     r_bcd;
    logic [4*DIGITS-1:0]     adj_bcd;
    logic [CNT_W-1:0]        r_cnt;
    logic                    accept;
    t_kind                   in_kind;

    always_comb begin
        unique case (i_cmd)
            CMD_INIT:   in_kind = K_INIT;
            CMD_RAW:    in_kind = K_RAW;
            CMD_DATA:   in_kind = K_DATA;
            CMD_CURSOR: in_kind = K_CURSOR;
            CMD_NUMBER: in_kind = K_NUMBER;
            default:    in_kind = K_GLYPH;
        endcase
    end

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                adj_bcd[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                adj_bcd[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        accept   = 1'b0;
        o_q_push = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    accept = 1'b1;
                    priority if (i_cmd == CMD_NUMBER) begin
                        n_state = F_CONV;
                    end else if (i_cmd <= CMD_GLYPH) begin
                        n_state = F_PUSH;
                    end else begin
                        n_state = F_IDLE; // drop unused request codes
                    end
                end
            end
            F_CONV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job.kind       <= in_kind;
            r_job.byte_value <= i_byte_value;
            r_job.cursor     <= {1'b1, i_row, i_column};
            r_job.slot       <= i_glyph_slot;
            r_job.rows       <= i_glyph_rows;
            r_bin            <= i_number;
            r_bcd            <= '0;
            r_cnt            <= '0;
        end else if (r_state == F_CONV) begin
            r_bcd <= {adj_bcd[4*DIGITS-2:0], r_bin[NUMBER_BITS-1]};
            r_bin <= {r_bin[NUMBER_BITS-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_full = (r_state != F_IDLE);
    assign o_job  = r_job;
    assign o_bcd  = r_bcd;

endmodule

[hw/rtl/lcdws_queue.sv]
// Two-entry job queue between the intake and the write sequencer.
module lcdws_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hw/rtl/lcdws_back.sv]
// Write sequencer: expands one job into bus writes behind an output register.
module lcdws_back
    import lcdws_pkg::*;
#(
    parameter int DIGITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  t_job                i_job,
    input  logic [4*DIGITS-1:0] i_bcd,
    output logic                o_empty,
    input  logic                i_pop,
    output logic                o_is_data,
    output logic [7:0]          o_bus_byte,
    output logic                o_last
);

    localparam int DIG_W = $clog2(DIGITS);
    localparam logic [DIG_W-1:0] DIG_TOP = DIG_W'(DIGITS - 1);

    t_back_state         r_state, n_state;
    t_job                r_job;
    logic [4*DIGITS-1:0] r_bcd;
    logic [3:0]          r_step;
    logic [DIG_W-1:0]    r_dig;
    logic                r_started;
    logic                r_out_valid;
    logic                r_out_is_data;
    logic [7:0]          r_out_byte;
    logic                r_out_last;

    logic       slot_free;
    logic       skip;
    logic       emit;
    logic       load;
    logic [3:0] digit;
    logic [2:0] row_idx;
    logic       wr_is_data;
    logic [7:0] wr_byte;
    logic       wr_last;

    assign slot_free = !r_out_valid || i_pop;
    assign digit     = r_bcd[r_dig*4 +: 4];
    assign row_idx   = 3'(r_step - 4'd1);
    // skip leading zeros, but always print the ones digit
    assign skip      = (r_state == B_RUN) && (r_job.kind == K_NUMBER) && !r_started
                       && (digit == 4'd0) && (r_dig != '0);
    assign emit      = (r_state == B_RUN) && !skip && slot_free;

    always_comb begin
        wr_is_data = 1'b0;
        wr_byte    = r_job.byte_value;
        wr_last    = 1'b1;
        unique case (r_job.kind)
            K_INIT: begin
                unique case (r_step)
                    ISTEP_FUNCTION: begin
                        wr_byte = OP_FUNCTION_SET;
                        wr_last = 1'b0;
                    end
                    ISTEP_DISPLAY: begin
                        wr_byte = OP_DISPLAY_ON;
                        wr_last = 1'b0;
                    end
                    default: wr_byte = OP_CLEAR;
                endcase
            end
            K_RAW:    wr_byte = r_job.byte_value;
            K_DATA:   wr_is_data = 1'b1;
            K_CURSOR: wr_byte = r_job.cursor;
            K_NUMBER: begin
                wr_is_data = 1'b1;
                wr_byte    = {ASCII_DIGIT_HI, digit};
                wr_last    = (r_dig == '0);
            end
            K_GLYPH: begin
                priority if (r_step == GSTEP_CGRAM) begin
                    wr_byte = {2'b01, r_job.slot, 3'b000};
                    wr_last = 1'b0;
                end else if (r_step <= GSTEP_LAST_ROW) begin
                    wr_is_data = 1'b1;
                    wr_byte    = r_job.rows[row_idx*8 +: 8];
                    wr_last    = 1'b0;
                end else if (r_step == GSTEP_CURSOR) begin
                    wr_byte = r_job.cursor;
                    wr_last = 1'b0;
                end else begin
                    wr_is_data = 1'b1;
                    wr_byte    = {5'd0, r_job.slot};
                end
            end
            default: wr_last = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    load    = 1'b1;
                    n_state = B_RUN;
                end
            end
            B_RUN: begin
                if (emit && wr_last) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job     <= i_job;
            r_bcd     <= i_bcd;
            r_step    <= '0;
            r_dig     <= DIG_TOP;
            r_started <= 1'b0;
        end else if (skip) begin
            r_dig <= r_dig - 1'b1;
        end else if (emit) begin
            r_step    <= r_step + 1'b1;
            r_started <= 1'b1;
            if (r_dig != '0) begin
                r_dig <= r_dig - 1'b1;
            end
        end
        if (emit) begin
            r_out_is_data <= wr_is_data;
            r_out_byte    <= wr_byte;
            r_out_last    <= wr_last;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_is_data  = r_out_is_data;
    assign o_bus_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

[hw/rtl/char_lcd_write_sequencer.sv]
// A request passes the intake register, the job queue, the sequencer and its output
//   register; a number is converted to BCD first and its leading zeros are skipped.
// The intake is full until its request is in the queue, so it holds one at a time;
//   the sequencer gives one write per cycle while its output register is free.
// Reset (synchronous, active low) empties the job queue and the output register.
module char_lcd_write_sequencer
    import lcdws_pkg::*;
#(
    parameter int NUMBER_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [2:0]              i_cmd,
    input  logic [7:0]              i_byte_value,
    input  logic                    i_row,
    input  logic [5:0]              i_column,
    input  logic [NUMBER_BITS-1:0]  i_number,
    input  logic [2:0]              i_glyph_slot,
    input  logic [GLYPH_ROWS_W-1:0] i_glyph_rows,
    output logic                    empty,
    input  logic                    pop,
    output logic                    o_is_data,
    output logic [7:0]              o_bus_byte,
    output logic                    o_last
);

    localparam int DIGITS = (NUMBER_BITS * 30103) / 100000 + 1;
    localparam int JOB_W  = $bits(t_job);
    localparam int DATA_W = JOB_W + 4 * DIGITS;

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    t_job                front_job;
    logic [4*DIGITS-1:0] front_bcd;
    logic [DATA_W-1:0]   q_out;
    t_job                back_job;
    logic [4*DIGITS-1:0] back_bcd;

    lcdws_front #(
        .NUMBER_BITS(NUMBER_BITS),
        .DIGITS     (DIGITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_cmd       (i_cmd),
        .i_byte_value(i_byte_value),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_number    (i_number),
        .i_glyph_slot(i_glyph_slot),
        .i_glyph_rows(i_glyph_rows),
        .o_q_push    (q_push),
        .i_q_full    (q_full),
        .o_job       (front_job),
        .o_bcd       (front_bcd)
    );

    lcdws_queue #(
        .DATA_W(DATA_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .o_full (q_full),
        .i_data ({front_job, front_bcd}),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_data (q_out)
    );

    assign back_job = t_job'(q_out[DATA_W-1 -: JOB_W]);
    assign back_bcd = q_out[4*DIGITS-1:0];

    lcdws_back #(
        .DIGITS(DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_job     (back_job),
        .i_bcd     (back_bcd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_is_data (o_is_data),
        .o_bus_byte(o_bus_byte),
        .o_last    (o_last)
    );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the character LCD write sequencer.
`timescale 1ns / 1ps

module testbench;
    import lcdws_pkg::*;

    localparam int NUMBER_W = 32;

    // Request codes the block ignores
    localparam logic [2:0] CMD_UNUSED_A = 3'd6;
    localparam logic [2:0] CMD_UNUSED_B = 3'd7;

    localparam logic [7:0] DDRAM_BASE   = 8'h80;
    localparam logic [7:0] CGRAM_BASE   = 8'h40;
    localparam logic [7:0] LINE2_OFFSET = 8'h40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;

    localparam int ITEMS_PER_PHASE = 110;
    localparam int HOLD_CYCLES     = 600;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 100;

    typedef struct {
        logic [2:0]              cmd;
        logic [7:0]              byte_value;
        logic                    row;
        logic [5:0]              column;
        logic [NUMBER_W-1:0]     number;
        logic [2:0]              glyph_slot;
        logic [GLYPH_ROWS_W-1:0] glyph_rows;
    } lcd_request_t;

    typedef struct {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } bus_write_t;

    // Expands each accepted request into its bus writes and matches them in order
    class bus_write_tracker;
        bus_write_t expected_writes[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function automatic logic [7:0] cursor_byte(logic row, logic [5:0] column);
            return DDRAM_BASE + {2'b00, column} + (row ? LINE2_OFFSET : 8'h00);
        endfunction

        function void add_write(ref bus_write_t run[$], input logic is_data,
                                input logic [7:0] value);
            bus_write_t w;
            w.is_data  = is_data;
            w.bus_byte = value;
            w.last     = 1'b0;
            run.push_back(w);
        endfunction

        function void note_request(lcd_request_t r);
            bus_write_t          run[$];
            logic [7:0]          digits[$];
            logic [NUMBER_W-1:0] v;
            case (r.cmd)
                CMD_INIT: begin
                    add_write(run, 1'b0, OP_FUNCTION_SET);
                    add_write(run, 1'b0, OP_DISPLAY_ON);
                    add_write(run, 1'b0, OP_CLEAR);
                end
                CMD_RAW:    add_write(run, 1'b0, r.byte_value);
                CMD_DATA:   add_write(run, 1'b1, r.byte_value);
                CMD_CURSOR: add_write(run, 1'b0, cursor_byte(r.row, r.column));
                CMD_NUMBER: begin
                    v = r.number;
                    do begin
                        digits.push_front(ASCII_ZERO + 8'(v % 10));
                        v = v / 10;
                    end while (v != 0);
                    foreach (digits[i]) add_write(run, 1'b1, digits[i]);
                end
                CMD_GLYPH: begin
                    add_write(run, 1'b0, CGRAM_BASE + {2'b00, r.glyph_slot, 3'b000});
                    for (int i = 0; i < GLYPH_HEIGHT; i++)
                        add_write(run, 1'b1, r.glyph_rows[8*i +: 8]);
                    add_write(run, 1'b0, cursor_byte(r.row, r.column));
                    add_write(run, 1'b1, {5'b00000, r.glyph_slot});
                end
                default: ;
            endcase
            if (run.size() > 0) begin
                run[run.size()-1].last = 1'b1;
                foreach (run[i]) expected_writes.push_back(run[i]);
            end
        endfunction

        function void check_write(logic is_data, logic [7:0] bus_byte, logic last);
            bus_write_t e;
            if (expected_writes.size() == 0) begin
                $display("%0t: unexpected write: is_data=%b bus_byte=%h last=%b",
                         $time, is_data, bus_byte, last);
                errors++;
                return;
            end
            e = expected_writes.pop_front();
            if (is_data !== e.is_data) begin
                $display("%0t: is_data mismatch: expected %b, actual %b",
                         $time, e.is_data, is_data);
                errors++;
            end
            if (bus_byte !== e.bus_byte) begin
                $display("%0t: bus_byte mismatch: expected %h, actual %h",
                         $time, e.bus_byte, bus_byte);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last mismatch: expected %b, actual %b",
                         $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic [2:0]              i_cmd;
    logic [7:0]              i_byte_value;
    logic                    i_row;
    logic [5:0]              i_column;
    logic [NUMBER_W-1:0]     i_number;
    logic [2:0]              i_glyph_slot;
    logic [GLYPH_ROWS_W-1:0] i_glyph_rows;
    logic                    empty;
    logic                    pop;
    logic                    o_is_data;
    logic [7:0]              o_bus_byte;
    logic                    o_last;

    bus_write_tracker tracker = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    char_lcd_write_sequencer #(
        .NUMBER_BITS(NUMBER_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_cmd       (i_cmd),
        .i_byte_value(i_byte_value),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_number    (i_number),
        .i_glyph_slot(i_glyph_slot),
        .i_glyph_rows(i_glyph_rows),
        .empty       (empty),
        .pop         (pop),
        .o_is_data   (o_is_data),
        .o_bus_byte  (o_bus_byte),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            tracker.check_write(o_is_data, o_bus_byte, o_last);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(lcd_request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        i_cmd        <= r.cmd;
        i_byte_value <= r.byte_value;
        i_row        <= r.row;
        i_column     <= r.column;
        i_number     <= r.number;
        i_glyph_slot <= r.glyph_slot;
        i_glyph_rows <= r.glyph_rows;
        push         <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        tracker.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic send_fields(logic [2:0] cmd, logic [7:0] byte_value, logic row,
                               logic [5:0] column, logic [NUMBER_W-1:0] number,
                               logic [2:0] glyph_slot, logic [GLYPH_ROWS_W-1:0] glyph_rows);
        lcd_request_t r;
        r.cmd        = cmd;
        r.byte_value = byte_value;
        r.row        = row;
        r.column     = column;
        r.number     = number;
        r.glyph_slot = glyph_slot;
        r.glyph_rows = glyph_rows;
        send_request(r);
    endtask

    function automatic lcd_request_t random_request();
        lcd_request_t    r;
        longint unsigned scaled;
        if ($urandom_range(99) < 4)
            r.cmd = $urandom_range(1) ? CMD_UNUSED_A : CMD_UNUSED_B;
        else
            r.cmd = 3'($urandom_range(int'(CMD_GLYPH)));
        r.byte_value = 8'($urandom);
        r.row        = 1'($urandom);
        r.column     = 6'($urandom);
        r.glyph_slot = 3'($urandom);
        r.glyph_rows = {$urandom, $urandom};
        // Mix of magnitudes so short, long and zero-tailed digit runs all occur
        case ($urandom_range(4))
            0: r.number = $urandom;
            1: r.number = $urandom_range(9);
            2: r.number = $urandom_range(99999);
            3: begin
                scaled = 1;
                repeat ($urandom_range(9)) scaled = scaled * 10;
                scaled = scaled * $urandom_range(1, 9);
                if (scaled > 64'hFFFF_FFFF) scaled = scaled / 10;
                r.number = NUMBER_W'(scaled);
            end
            default: r.number = 32'hFFFF_FFFF - $urandom_range(1000);
        endcase
        return r;
    endfunction

    task automatic run_random(int count);
        lcd_request_t r;
        int           sent = 0;
        while (sent < count) begin
            r = random_request();
            send_request(r);
            if (r.cmd <= CMD_GLYPH) sent++;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        i_cmd        = CMD_INIT;
        i_byte_value = '0;
        i_row        = 1'b0;
        i_column     = '0;
        i_number     = '0;
        i_glyph_slot = '0;
        i_glyph_rows = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_fields(CMD_INIT,     8'h00, 1'b0, 6'd0,  '0, 3'd0, '0);
        send_fields(CMD_RAW,      8'h00, 1'b0, 6'd0,  '0, 3'd0, '0);
        send_fields(CMD_RAW,      8'hFF, 1'b1, 6'd63, '1, 3'd7, '1);
        send_fields(CMD_DATA,     8'h00, 1'b0, 6'd0,  '0, 3'd0, '0);
        send_fields(CMD_DATA,     8'hFF, 1'b1, 6'd63, '1, 3'd7, '1);
        send_fields(CMD_CURSOR,   8'h00, 1'b0, 6'd0,  '0, 3'd0, '0);
        send_fields(CMD_CURSOR,   8'h00, 1'b1, 6'd63, '0, 3'd0, '0);
        send_fields(CMD_CURSOR,   8'h00, 1'b0, 6'd63, '0, 3'd0, '0);
        send_fields(CMD_CURSOR,   8'h00, 1'b1, 6'd0,  '0, 3'd0, '0);
        // Zero prints a single digit; zero-tailed values keep every zero
        send_fields(CMD_NUMBER,   8'h00, 1'b0, 6'd0,  32'd0,          3'd0, '0);
        send_fields(CMD_NUMBER,   8'h00, 1'b0, 6'd0,  32'd9,          3'd0, '0);
        send_fields(CMD_NUMBER,   8'h00, 1'b0, 6'd0,  32'd10,         3'd0, '0);
        send_fields(CMD_NUMBER,   8'h00, 1'b0, 6'd0,  32'd1000000000, 3'd0, '0);
        send_fields(CMD_NUMBER,   8'h00, 1'b0, 6'd0,  32'd4000000000, 3'd0, '0);
        send_fields(CMD_NUMBER,   8'h00, 1'b0, 6'd0,  32'hFFFF_FFFF,  3'd0, '0);
        send_fields(CMD_GLYPH,    8'h00, 1'b0, 6'd0,  '0, 3'd0, '0);
        send_fields(CMD_GLYPH,    8'h00, 1'b1, 6'd63, '0, 3'd7, '1);
        send_fields(CMD_GLYPH,    8'h00, 1'b0, 6'd5,  '0, 3'd3, 64'h0123_4567_89AB_CDEF);
        send_fields(CMD_UNUSED_A, 8'hFF, 1'b1, 6'd63, '1, 3'd7, '1);
        send_fields(CMD_UNUSED_B, 8'hFF, 1'b1, 6'd63, '1, 3'd7, '1);

        // Back to back with the receiver held off, so the input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        run_random(ITEMS_PER_PHASE);

        send_idle_pct = 48;
        run_random(ITEMS_PER_PHASE);

        send_idle_pct  = 0;
        recv_stall_pct = 48;
        run_random(ITEMS_PER_PHASE);

        send_idle_pct  = 36;
        recv_stall_pct = 36;
        run_random(ITEMS_PER_PHASE);
        push <= 1'b0;

        while (tracker.expected_writes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.expected_writes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
